@@ rtl/ectc_pkg.sv @@
// Shared types, constants and matrix helpers for the ECEF to camera rotation block.
package ectc_pkg;

  localparam int ANGLE_WIDTH    = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int COEF_WIDTH     = COEF_FRAC_BITS + 2;

  // Pipeline layout: sine/cosine stages, then matrix product stages.
  localparam int TRIG_STAGES = 8;
  localparam int MAT_STAGES  = 5;
  localparam int PIPE_STAGES = TRIG_STAGES + MAT_STAGES;
  localparam int NUM_ANGLES  = 8;

  typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
  typedef logic signed [COEF_WIDTH-1:0]  coef_t;
  typedef coef_t [0:2][0:2]              mat_t;

  // Q30 quarter-turn fraction, wide enough to hold one quarter turn itself.
  typedef logic [30:0]        ufrac_t;
  // Horner accumulator of the sine polynomial.
  typedef logic signed [32:0] hacc_t;

  localparam coef_t ONE = coef_t'(1 << COEF_FRAC_BITS);

  // Odd Taylor coefficients of sin(pi/2 * t) in Q30, highest order first.
  localparam hacc_t SIN_COEF [7] = '{
    33'sd61, -33'sd3864, 33'sd172272, -33'sd5026995,
    33'sd85569306, -33'sd693598668, 33'sd1686629713
  };

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Fixed signed axis permutations around the transposed gimbal matrix.
  localparam mat_t PERM_A = '{
    '{coef_t'(0), ONE, coef_t'(0)},
    '{coef_t'(0), coef_t'(0), ONE},
    '{ONE, coef_t'(0), coef_t'(0)}
  };
  localparam mat_t PERM_D = '{
    '{coef_t'(0), ONE, coef_t'(0)},
    '{ONE, coef_t'(0), coef_t'(0)},
    '{coef_t'(0), coef_t'(0), -ONE}
  };

  typedef struct packed {
    angle_t latitude;
    angle_t longitude;
    angle_t gimbal_pitch_angle;
    angle_t gimbal_roll_angle;
    angle_t gimbal_yaw_angle;
    angle_t platform_pitch_angle;
    angle_t platform_roll_angle;
    angle_t platform_yaw_angle;
  } in_beat_t;

  typedef struct packed {
    coef_t m00;
    coef_t m01;
    coef_t m02;
    coef_t m10;
    coef_t m11;
    coef_t m12;
    coef_t m20;
    coef_t m21;
    coef_t m22;
  } out_beat_t;

  // 3x3 product: three full products summed, rounded once, saturated to +-1.0.
  function automatic mat_t mat_mul(input mat_t a, input mat_t b);
    logic signed [2*COEF_WIDTH-1:0] p0;
    logic signed [2*COEF_WIDTH-1:0] p1;
    logic signed [2*COEF_WIDTH-1:0] p2;
    logic signed [2*COEF_WIDTH+1:0] acc;
    logic signed [2*COEF_WIDTH-COEF_FRAC_BITS+1:0] rv;
    mat_t r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        p0  = $signed(a[i][0]) * $signed(b[0][j]);
        p1  = $signed(a[i][1]) * $signed(b[1][j]);
        p2  = $signed(a[i][2]) * $signed(b[2][j]);
        acc = p0 + p1 + p2;
        acc = acc + ((2*COEF_WIDTH+2)'(1) <<< (COEF_FRAC_BITS - 1));
        rv  = (2*COEF_WIDTH-COEF_FRAC_BITS+2)'(acc >>> COEF_FRAC_BITS);
        if (rv > ONE) begin
          r[i][j] = ONE;
        end else if (rv < -ONE) begin
          r[i][j] = -ONE;
        end else begin
          r[i][j] = coef_t'(rv);
        end
      end
    end
    return r;
  endfunction

  function automatic mat_t transpose(input mat_t a);
    mat_t r;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        r[i][j] = a[j][i];
      end
    end
    return r;
  endfunction

  // Elementary rotation about one axis from its sine and cosine.
  function automatic mat_t axis_rot(input axis_t axis, input coef_t s, input coef_t c);
    mat_t r;
    r = '0;
    r[0][0] = ONE;
    r[1][1] = ONE;
    r[2][2] = ONE;
    case (axis)
      AXIS_X: begin
        r[1][1] = c;
        r[1][2] = -s;
        r[2][1] = s;
        r[2][2] = c;
      end
      AXIS_Y: begin
        r[2][2] = c;
        r[2][0] = -s;
        r[0][2] = s;
        r[0][0] = c;
      end
      AXIS_Z: begin
        r[0][0] = c;
        r[0][1] = -s;
        r[1][0] = s;
        r[1][1] = c;
      end
      default: begin
        r[0][0] = ONE;
      end
    endcase
    return r;
  endfunction

  // Product of two trig values, rounded back to the coefficient format.
  function automatic coef_t trig_prod(input coef_t a, input coef_t b);
    logic signed [2*COEF_WIDTH-1:0] p;
    p = $signed(a) * $signed(b);
    p = p + ((2*COEF_WIDTH)'(1) <<< (COEF_FRAC_BITS - 1));
    return coef_t'(p >>> COEF_FRAC_BITS);
  endfunction

endpackage

@@ rtl/ectc_if.sv @@
// Valid/ready channel interfaces for the angle input and the matrix result.
interface ectc_in_if;
  logic               valid;
  logic               ready;
  ectc_pkg::in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ectc_out_if;
  logic                valid;
  logic                ready;
  ectc_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ecef_to_camera_rotation.sv @@
// Top level: ECEF to camera rotation matrix from position and attitude angles.
//
//   channel  | direction | handshake              | beat
//   in_ch    | in        | in_ch.valid/ready      | latitude, longitude, six Euler angles
//   out_ch   | out       | out_ch.valid/ready     | m00..m22, Q1.14 rotation matrix
//
// One beat is accepted per cycle unless every stage is full and the output is stalled; a result
// is offered after the eight sine/cosine stages and five matrix product stages.
// Each stage holds its own valid bit and loads whenever it is empty or its successor
// loads, so bubbles close up and a stalled output never drops or repeats a beat.
// Synchronous active-low reset clears only the valid bits.
module ecef_to_camera_rotation (
  input logic        clk,
  input logic        rst_n,
  ectc_in_if.sink    in_ch,
  ectc_out_if.source out_ch
);

  localparam int NS = ectc_pkg::PIPE_STAGES;
  localparam int TS = ectc_pkg::TRIG_STAGES;

  localparam int IDX_LAT = 0;
  localparam int IDX_LON = 1;
  localparam int IDX_GP  = 2;
  localparam int IDX_GR  = 3;
  localparam int IDX_GY  = 4;
  localparam int IDX_PP  = 5;
  localparam int IDX_PR  = 6;
  localparam int IDX_PY  = 7;

  logic [NS-1:0]     v_r;
  logic [NS-1:0]     v_nxt;
  logic [NS-1:0]     en;
  ectc_pkg::angle_t  ang_w [ectc_pkg::NUM_ANGLES];
  ectc_pkg::coef_t   sn_w  [ectc_pkg::NUM_ANGLES];
  ectc_pkg::coef_t   cs_w  [ectc_pkg::NUM_ANGLES];
  ectc_pkg::mat_t    lmat;

  ectc_pkg::mat_t    g1_r, p1_r, l1_r;
  ectc_pkg::coef_t   grs_r, grc_r, pys_r, pyc_r;
  ectc_pkg::mat_t    g2_r, p2_r, l2_r;
  ectc_pkg::mat_t    x3_r, p3_r, l3_r;
  ectc_pkg::mat_t    y4_r, l4_r;
  ectc_pkg::mat_t    r5_r;

  // Stage enables ripple back from the output handshake.
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  // Valid bits advance with their stage.
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) begin
        v_nxt[k] = (k == 0) ? in_ch.valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // Sine and cosine of all eight angles.
  assign ang_w[IDX_LAT] = in_ch.data.latitude;
  assign ang_w[IDX_LON] = in_ch.data.longitude;
  assign ang_w[IDX_GP]  = in_ch.data.gimbal_pitch_angle;
  assign ang_w[IDX_GR]  = in_ch.data.gimbal_roll_angle;
  assign ang_w[IDX_GY]  = in_ch.data.gimbal_yaw_angle;
  assign ang_w[IDX_PP]  = in_ch.data.platform_pitch_angle;
  assign ang_w[IDX_PR]  = in_ch.data.platform_roll_angle;
  assign ang_w[IDX_PY]  = in_ch.data.platform_yaw_angle;

  for (genvar a = 0; a < ectc_pkg::NUM_ANGLES; a++) begin : g_trig
    ectc_trig u_trig (
      .clk   (clk),
      .en    (en[TS-1:0]),
      .angle (ang_w[a]),
      .sin_r (sn_w[a]),
      .cos_r (cs_w[a])
    );
  end

  // East-north-up rotation from latitude and longitude.
  always_comb begin
    lmat       = '0;
    lmat[0][0] = -sn_w[IDX_LON];
    lmat[0][1] = cs_w[IDX_LON];
    lmat[1][0] = -ectc_pkg::trig_prod(sn_w[IDX_LAT], cs_w[IDX_LON]);
    lmat[1][1] = -ectc_pkg::trig_prod(sn_w[IDX_LAT], sn_w[IDX_LON]);
    lmat[1][2] = cs_w[IDX_LAT];
    lmat[2][0] = ectc_pkg::trig_prod(cs_w[IDX_LAT], cs_w[IDX_LON]);
    lmat[2][1] = ectc_pkg::trig_prod(cs_w[IDX_LAT], sn_w[IDX_LON]);
    lmat[2][2] = sn_w[IDX_LAT];
  end

  // First products: gimbal yaw by pitch, platform roll by pitch.
  always_ff @(posedge clk) begin
    if (en[TS]) begin
      g1_r  <= ectc_pkg::mat_mul(
                 ectc_pkg::axis_rot(ectc_pkg::AXIS_Z, sn_w[IDX_GY], cs_w[IDX_GY]),
                 ectc_pkg::axis_rot(ectc_pkg::AXIS_Y, sn_w[IDX_GP], cs_w[IDX_GP]));
      p1_r  <= ectc_pkg::mat_mul(
                 ectc_pkg::axis_rot(ectc_pkg::AXIS_Y, sn_w[IDX_PR], cs_w[IDX_PR]),
                 ectc_pkg::axis_rot(ectc_pkg::AXIS_X, sn_w[IDX_PP], cs_w[IDX_PP]));
      l1_r  <= lmat;
      grs_r <= sn_w[IDX_GR];
      grc_r <= cs_w[IDX_GR];
      pys_r <= sn_w[IDX_PY];
      pyc_r <= cs_w[IDX_PY];
    end
  end

  // Third rotation of each chain.
  always_ff @(posedge clk) begin
    if (en[TS+1]) begin
      g2_r <= ectc_pkg::mat_mul(g1_r, ectc_pkg::axis_rot(ectc_pkg::AXIS_X, grs_r, grc_r));
      p2_r <= ectc_pkg::mat_mul(p1_r, ectc_pkg::axis_rot(ectc_pkg::AXIS_Z, pys_r, pyc_r));
      l2_r <= l1_r;
    end
  end

  // Transposed gimbal matrix framed by the fixed permutations.
  always_ff @(posedge clk) begin
    if (en[TS+2]) begin
      x3_r <= ectc_pkg::mat_mul(
                ectc_pkg::mat_mul(ectc_pkg::PERM_A, ectc_pkg::transpose(g2_r)),
                ectc_pkg::PERM_D);
      p3_r <= p2_r;
      l3_r <= l2_r;
    end
  end

  // Apply the platform attitude.
  always_ff @(posedge clk) begin
    if (en[TS+3]) begin
      y4_r <= ectc_pkg::mat_mul(x3_r, p3_r);
      l4_r <= l3_r;
    end
  end

  // Apply the local-frame rotation; this is the output register.
  always_ff @(posedge clk) begin
    if (en[TS+4]) begin
      r5_r <= ectc_pkg::mat_mul(y4_r, l4_r);
    end
  end

  assign out_ch.valid    = v_r[NS-1];
  assign out_ch.data.m00 = r5_r[0][0];
  assign out_ch.data.m01 = r5_r[0][1];
  assign out_ch.data.m02 = r5_r[0][2];
  assign out_ch.data.m10 = r5_r[1][0];
  assign out_ch.data.m11 = r5_r[1][1];
  assign out_ch.data.m12 = r5_r[1][2];
  assign out_ch.data.m20 = r5_r[2][0];
  assign out_ch.data.m21 = r5_r[2][1];
  assign out_ch.data.m22 = r5_r[2][2];

  // Input is refused only when every stage holds a beat.
  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&v_r))
    else $error("input stalled while the pipeline has an empty stage");

  // An accepted beat occupies the first stage on the next edge.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> v_r[0])
    else $error("accepted beat did not enter the pipeline");

  // Latitude sine and longitude cosine stay within +-1.0 once valid.
  a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[TS-1] |-> ($signed(sn_w[IDX_LAT]) <= $signed(ectc_pkg::ONE) &&
                   $signed(sn_w[IDX_LAT]) >= -$signed(ectc_pkg::ONE) &&
                   $signed(cs_w[IDX_LON]) <= $signed(ectc_pkg::ONE) &&
                   $signed(cs_w[IDX_LON]) >= -$signed(ectc_pkg::ONE)))
    else $error("trig value outside the unit range");

  // Result entries are saturated to +-1.0.
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.data.m00) <= $signed(ectc_pkg::ONE) &&
                      $signed(out_ch.data.m00) >= -$signed(ectc_pkg::ONE) &&
                      $signed(out_ch.data.m22) <= $signed(ectc_pkg::ONE) &&
                      $signed(out_ch.data.m22) >= -$signed(ectc_pkg::ONE)))
    else $error("result entry outside the unit range");

endmodule

@@ rtl/ectc_trig.sv @@
// Pipelined sine and cosine of one binary angle by a Horner polynomial.
module ectc_trig (
  input  logic                                clk,
  input  logic [ectc_pkg::TRIG_STAGES-1:0]    en,
  input  ectc_pkg::angle_t                    angle,
  output ectc_pkg::coef_t                     sin_r,
  output ectc_pkg::coef_t                     cos_r
);

  localparam int SH    = 30 - ectc_pkg::COEF_FRAC_BITS;
  localparam int HORN  = ectc_pkg::TRIG_STAGES - 2;
  localparam int LAST  = ectc_pkg::TRIG_STAGES - 1;

  logic [31:0]       phase;
  logic [1:0]        quad_r [LAST];
  ectc_pkg::ufrac_t  lane_t [2];
  ectc_pkg::ufrac_t  t_r    [2][LAST];
  ectc_pkg::ufrac_t  t2_r   [2][HORN];
  ectc_pkg::hacc_t   acc_r  [2][HORN];
  ectc_pkg::ufrac_t  mag    [2];
  ectc_pkg::ufrac_t  sin_mag;
  ectc_pkg::ufrac_t  cos_mag;
  logic              sin_neg;
  logic              cos_neg;

  // Signed magnitude in Q30 rounded to the coefficient format.
  function automatic ectc_pkg::coef_t to_coef(input ectc_pkg::ufrac_t m, input logic neg);
    logic signed [31:0] v;
    v = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
    v = v + (32'sd1 <<< (SH - 1));
    return ectc_pkg::coef_t'(v >>> SH);
  endfunction

  // Phase left-aligned to 32 bits: quadrant on top, quarter-turn fraction below.
  assign phase     = 32'(angle) << (32 - ectc_pkg::ANGLE_WIDTH);
  assign lane_t[0] = {1'b0, phase[29:0]};
  assign lane_t[1] = 31'h4000_0000 - {1'b0, phase[29:0]};

  // Quadrant travels alongside the polynomial lanes.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      quad_r[0] <= phase[31:30];
    end
    for (int k = 1; k < LAST; k++) begin
      if (en[k]) begin
        quad_r[k] <= quad_r[k-1];
      end
    end
  end

  // Lane 0 evaluates S(t), lane 1 evaluates S(1 - t).
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [61:0]        sq;
    logic signed [64:0] fprod;
    logic signed [34:0] fval;

    assign sq = 62'(lane_t[l]) * 62'(lane_t[l]) + 62'(32'h2000_0000);

    always_ff @(posedge clk) begin
      if (en[0]) begin
        t_r[l][0]  <= lane_t[l];
        t2_r[l][0] <= sq[60:30];
      end
    end

    for (genvar k = 1; k <= HORN; k++) begin : g_horner
      ectc_pkg::hacc_t    prev;
      logic signed [64:0] prod;

      if (k == 1) begin : g_first
        assign prev = ectc_pkg::SIN_COEF[0];
      end else begin : g_next
        assign prev = acc_r[l][k-2];
      end

      assign prod = prev * $signed({1'b0, t2_r[l][k-1]}) + (65'sd1 <<< 29);

      always_ff @(posedge clk) begin
        if (en[k]) begin
          acc_r[l][k-1] <= ectc_pkg::SIN_COEF[k] + ectc_pkg::hacc_t'(prod >>> 30);
          t_r[l][k]     <= t_r[l][k-1];
        end
      end

      if (k < HORN) begin : g_t2
        always_ff @(posedge clk) begin
          if (en[k]) begin
            t2_r[l][k] <= t2_r[l][k-1];
          end
        end
      end
    end

    // Final multiply by t, then clamp to [0, 1.0].
    assign fprod = acc_r[l][HORN-1] * $signed({1'b0, t_r[l][LAST-1]}) + (65'sd1 <<< 29);
    assign fval  = 35'(fprod >>> 30);

    always_comb begin
      if (fval < 0) begin
        mag[l] = '0;
      end else if (fval > 35'sh4000_0000) begin
        mag[l] = 31'h4000_0000;
      end else begin
        mag[l] = fval[30:0];
      end
    end
  end

  // Quadrant folding: cosine is the sine one quadrant ahead.
  always_comb begin
    sin_mag = quad_r[LAST-1][0] ? mag[1] : mag[0];
    cos_mag = quad_r[LAST-1][0] ? mag[0] : mag[1];
    sin_neg = quad_r[LAST-1][1];
    cos_neg = quad_r[LAST-1][1] ^ quad_r[LAST-1][0];
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      sin_r <= to_coef(sin_mag, sin_neg);
      cos_r <= to_coef(cos_mag, cos_neg);
    end
  end

endmodule

@@ sim/tb_ecef_to_camera_rotation_checker.sv @@
// Checker that predicts the rotation matrix of every input beat and compares results.
module tb_ecef_to_camera_rotation_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  ectc_pkg::in_beat_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  ectc_pkg::out_beat_t out_data,
  output int                  mismatch_count,
  output int                  pending_count
);

  typedef longint q_mat_t [0:2][0:2];

  localparam longint UNIT_Q = longint'(1) <<< ectc_pkg::COEF_FRAC_BITS;
  localparam longint QUARTER_ONE = longint'(1) <<< 30;
  localparam longint SINE_TAYLOR [7] = '{
    61, -3864, 172272, -5026995, 85569306, -693598668, 1686629713
  };

  ectc_pkg::out_beat_t expected_matrices [$];

  // Round to nearest with ties toward plus infinity, then drop s fraction bits.
  function automatic longint round_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v > UNIT_Q) return UNIT_Q;
    if (v < -UNIT_Q) return -UNIT_Q;
    return v;
  endfunction

  // sin(pi/2 * t) for t a Q30 fraction of a quarter turn.
  function automatic longint quarter_sine(longint t);
    longint t2;
    longint acc;
    t2  = round_shift(t * t, 30);
    acc = SINE_TAYLOR[0];
    for (int i = 1; i < 7; i++) acc = SINE_TAYLOR[i] + round_shift(acc * t2, 30);
    acc = round_shift(acc * t, 30);
    if (acc < 0) acc = 0;
    if (acc > QUARTER_ONE) acc = QUARTER_ONE;
    return acc;
  endfunction

  function automatic longint phase_sine(logic [31:0] p);
    longint t;
    longint v;
    t = longint'(p[29:0]);
    v = p[30] ? quarter_sine(QUARTER_ONE - t) : quarter_sine(t);
    if (p[31]) v = -v;
    return round_shift(v, 30 - ectc_pkg::COEF_FRAC_BITS);
  endfunction

  function automatic void sin_cos(input ectc_pkg::angle_t ang, output longint s,
                                  output longint c);
    logic [31:0] p;
    p = {ang, {(32 - ectc_pkg::ANGLE_WIDTH){1'b0}}};
    s = phase_sine(p);
    c = phase_sine(p + 32'h4000_0000);
  endfunction

  function automatic q_mat_t mat_product(q_mat_t a, q_mat_t b);
    q_mat_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i][j] = clamp_unit(round_shift(a[i][0] * b[0][j] + a[i][1] * b[1][j]
                                         + a[i][2] * b[2][j], ectc_pkg::COEF_FRAC_BITS));
    return r;
  endfunction

  function automatic q_mat_t elementary_rotation(ectc_pkg::axis_t axis,
                                                ectc_pkg::angle_t ang);
    q_mat_t r;
    longint s;
    longint c;
    int a;
    int b;
    sin_cos(ang, s, c);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i][j] = (i == j) ? UNIT_Q : 0;
    a = (axis == ectc_pkg::AXIS_X) ? 1 : (axis == ectc_pkg::AXIS_Y) ? 2 : 0;
    b = (axis == ectc_pkg::AXIS_X) ? 2 : (axis == ectc_pkg::AXIS_Y) ? 0 : 1;
    r[a][a] = c;
    r[a][b] = -s;
    r[b][a] = s;
    r[b][b] = c;
    return r;
  endfunction

  function automatic q_mat_t from_coef(ectc_pkg::mat_t m);
    q_mat_t r;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        r[i][j] = longint'(m[i][j]);
    return r;
  endfunction

  // Full camera rotation: permuted transposed gimbal, platform, then local level frame.
  function automatic ectc_pkg::out_beat_t camera_rotation(ectc_pkg::in_beat_t b);
    q_mat_t g;
    q_mat_t gt;
    q_mat_t acc;
    q_mat_t enu;
    longint sl;
    longint cl;
    longint sn;
    longint cn;
    ectc_pkg::out_beat_t r;
    g = mat_product(elementary_rotation(ectc_pkg::AXIS_Z, b.gimbal_yaw_angle),
                    elementary_rotation(ectc_pkg::AXIS_Y, b.gimbal_pitch_angle));
    g = mat_product(g, elementary_rotation(ectc_pkg::AXIS_X, b.gimbal_roll_angle));
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        gt[i][j] = g[j][i];
    acc = mat_product(from_coef(ectc_pkg::PERM_A), gt);
    acc = mat_product(acc, from_coef(ectc_pkg::PERM_D));

    g = mat_product(elementary_rotation(ectc_pkg::AXIS_Y, b.platform_roll_angle),
                    elementary_rotation(ectc_pkg::AXIS_X, b.platform_pitch_angle));
    g = mat_product(g, elementary_rotation(ectc_pkg::AXIS_Z, b.platform_yaw_angle));
    acc = mat_product(acc, g);

    sin_cos(b.latitude, sl, cl);
    sin_cos(b.longitude, sn, cn);
    enu[0][0] = -sn;
    enu[0][1] = cn;
    enu[0][2] = 0;
    enu[1][0] = -round_shift(sl * cn, ectc_pkg::COEF_FRAC_BITS);
    enu[1][1] = -round_shift(sl * sn, ectc_pkg::COEF_FRAC_BITS);
    enu[1][2] = cl;
    enu[2][0] = round_shift(cl * cn, ectc_pkg::COEF_FRAC_BITS);
    enu[2][1] = round_shift(cl * sn, ectc_pkg::COEF_FRAC_BITS);
    enu[2][2] = sl;
    acc = mat_product(acc, enu);

    r.m00 = ectc_pkg::coef_t'(acc[0][0]);
    r.m01 = ectc_pkg::coef_t'(acc[0][1]);
    r.m02 = ectc_pkg::coef_t'(acc[0][2]);
    r.m10 = ectc_pkg::coef_t'(acc[1][0]);
    r.m11 = ectc_pkg::coef_t'(acc[1][1]);
    r.m12 = ectc_pkg::coef_t'(acc[1][2]);
    r.m20 = ectc_pkg::coef_t'(acc[2][0]);
    r.m21 = ectc_pkg::coef_t'(acc[2][1]);
    r.m22 = ectc_pkg::coef_t'(acc[2][2]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  assign pending_count = expected_matrices.size();

  // Compare each result beat entry by entry against the oldest prediction.
  always @(posedge clk) begin
    ectc_pkg::out_beat_t want;
    ectc_pkg::coef_t     got_e [9];
    ectc_pkg::coef_t     want_e [9];
    if (!rst_n) begin
      mismatch_count = 0;
    end else begin
      if (in_valid && in_ready) expected_matrices.push_back(camera_rotation(in_data));
      if (out_valid && out_ready) begin
        if (expected_matrices.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          want = expected_matrices.pop_front();
          {got_e[0], got_e[1], got_e[2], got_e[3], got_e[4], got_e[5], got_e[6],
           got_e[7], got_e[8]} = out_data;
          {want_e[0], want_e[1], want_e[2], want_e[3], want_e[4], want_e[5],
           want_e[6], want_e[7], want_e[8]} = want;
          for (int k = 0; k < 9; k++)
            if (got_e[k] !== want_e[k])
              report_mismatch($sformatf("m%0d%0d", k / 3, k % 3), got_e[k], want_e[k]);
        end
      end
    end
  end
endmodule

@@ sim/tb_ecef_to_camera_rotation.sv @@
// Testbench top: angle stimulus, result back-pressure and the final verdict.
module tb_ecef_to_camera_rotation;

  localparam int RANDOM_BEATS = 1330;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   pending_count;

  ectc_in_if  in_ch ();
  ectc_out_if out_ch ();

  ecef_to_camera_rotation dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  tb_ecef_to_camera_rotation_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ch.ready),
    .in_data       (in_ch.data),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_data      (out_ch.data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mostly back-to-back, sometimes short pauses, rarely long ones.
  function automatic int idle_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Angles that sit on quadrant edges, wrap points and sign extremes.
  function automatic ectc_pkg::angle_t edge_angle();
    ectc_pkg::angle_t picks [12] = '{16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000,
                                     16'h8001, 16'h4000, 16'h3FFF, 16'hC000, 16'hBFFF,
                                     16'h2000, 16'hE000};
    return picks[$urandom_range(0, 11)] + ectc_pkg::angle_t'($urandom_range(0, 2))
           - 16'sd1;
  endfunction

  function automatic ectc_pkg::in_beat_t random_beat(bit near_edges);
    ectc_pkg::in_beat_t b;
    b = ectc_pkg::in_beat_t'({$urandom, $urandom, $urandom, $urandom});
    if (near_edges) begin
      if ($urandom_range(0, 1)) b.latitude = edge_angle();
      if ($urandom_range(0, 1)) b.longitude = edge_angle();
      if ($urandom_range(0, 1)) b.gimbal_pitch_angle = edge_angle();
      if ($urandom_range(0, 1)) b.gimbal_roll_angle = edge_angle();
      if ($urandom_range(0, 1)) b.gimbal_yaw_angle = edge_angle();
      if ($urandom_range(0, 1)) b.platform_pitch_angle = edge_angle();
      if ($urandom_range(0, 1)) b.platform_roll_angle = edge_angle();
      if ($urandom_range(0, 1)) b.platform_yaw_angle = edge_angle();
    end
    return b;
  endfunction

  function automatic ectc_pkg::in_beat_t uniform_beat(ectc_pkg::angle_t a);
    return ectc_pkg::in_beat_t'({8{a}});
  endfunction

  // Offer one beat and hold it until the block takes it.
  task automatic send_angles(input ectc_pkg::in_beat_t b);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.data  <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    gap = idle_cycles();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    rst_n        = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all angles on one value, then each angle alone at a quadrant edge.
    send_angles(uniform_beat(16'h0000));
    send_angles(uniform_beat(16'h7FFF));
    send_angles(uniform_beat(16'h8000));
    send_angles(uniform_beat(16'hFFFF));
    send_angles(uniform_beat(16'h4000));
    send_angles(uniform_beat(16'hC000));
    send_angles(uniform_beat(16'h2000));
    send_angles(uniform_beat(16'h0001));
    send_angles(uniform_beat(16'h8001));
    for (int k = 0; k < 8; k++) begin
      ectc_pkg::in_beat_t b;
      b = '0;
      b[k*ectc_pkg::ANGLE_WIDTH +: ectc_pkg::ANGLE_WIDTH] = (k % 2) ? 16'h8000 : 16'h4000;
      send_angles(b);
    end
    // Plus and minus pi must agree; these exercise the wrap of the phase.
    send_angles(uniform_beat(16'h8000));
    send_angles(ectc_pkg::in_beat_t'({4{32'h7FFF_8000}}));
    send_angles(ectc_pkg::in_beat_t'({4{32'h2AAA_D556}}));

    for (int n = 0; n < RANDOM_BEATS; n++) send_angles(random_beat($urandom_range(0, 3) == 0));
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("tb_ecef_to_camera_rotation: PASS");
    end else begin
      $display("tb_ecef_to_camera_rotation: FAIL");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off so the pipeline fills up, and a stretch of steady ready.
  initial begin
    int beats_taken;
    int hold;
    beats_taken = 0;
    hold = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (out_ch.valid && out_ch.ready) beats_taken++;
      if (beats_taken == 300 && hold == 0) hold = 120;
      if (hold > 1) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (hold == 1) begin
        hold = -1;
        out_ch.ready <= 1'b1;
      end else if (beats_taken > 600 && beats_taken < 800) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= (idle_cycles() == 0) || ($urandom_range(0, 2) != 0);
      end
      @(posedge clk);
    end
  end

  initial begin
    #2000000;
    $display("tb_ecef_to_camera_rotation: FAIL");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/ectc_pkg.sv
rtl/ectc_if.sv
rtl/ectc_trig.sv
rtl/ecef_to_camera_rotation.sv
sim/tb_ecef_to_camera_rotation_checker.sv
sim/tb_ecef_to_camera_rotation.sv
